FILE: hdl/lcsr_pkg.sv
`timescale 1ns / 1ps
package lcsr_pkg;

  localparam int SHIFT_W = 5;
  localparam int POS_W   = 16;
  localparam int COLOR_W = 8;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } chain_ctrl_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_t;

endpackage

FILE: hdl/lcsr_if.sv
`timescale 1ns / 1ps
interface lcsr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lcsr_pkg::POS_W-1:0]   pos_x;
  logic signed [lcsr_pkg::POS_W-1:0]   pos_y;
  logic        [lcsr_pkg::COLOR_W-1:0] red;
  logic        [lcsr_pkg::COLOR_W-1:0] green;
  logic        [lcsr_pkg::COLOR_W-1:0] blue;
  logic                                frame_end;

  modport source (output valid, pos_x, pos_y, red, green, blue, frame_end, input ready);
  modport sink (input valid, pos_x, pos_y, red, green, blue, frame_end, output ready);
endinterface

interface lcsr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lcsr_pkg::POS_W-1:0]   out_x;
  logic signed [lcsr_pkg::POS_W-1:0]   out_y;
  logic        [lcsr_pkg::COLOR_W-1:0] out_red;
  logic        [lcsr_pkg::COLOR_W-1:0] out_green;
  logic        [lcsr_pkg::COLOR_W-1:0] out_blue;
  logic                                out_frame_end;

  modport source (output valid, out_x, out_y, out_red, out_green, out_blue, out_frame_end,
                  input ready);
  modport sink (input valid, out_x, out_y, out_red, out_green, out_blue, out_frame_end,
                output ready);
endinterface

FILE: hdl/lcsr_cell.sv
`timescale 1ns / 1ps
module lcsr_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcsr_pkg::chain_ctrl_t ctrl,
  input  lcsr_pkg::rgb_t       d_in,
  output lcsr_pkg::rgb_t       q
);
  import lcsr_pkg::*;

  rgb_t data_r;
  rgb_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.clear) begin
      data_nxt = '0;
    end else if (ctrl.advance) begin
      data_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign q = data_r;
endmodule

FILE: hdl/lcsr_delay_chain.sv
`timescale 1ns / 1ps
module lcsr_delay_chain #(
  parameter int MAX_SHIFT = 31,
  parameter int SHW       = $clog2(MAX_SHIFT + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcsr_pkg::chain_ctrl_t ctrl,
  input  lcsr_pkg::rgb_t        push_rgb,
  input  logic [SHW-1:0]        tap_sel,
  output lcsr_pkg::rgb_t        tap_rgb
);
  import lcsr_pkg::*;

  localparam int IW = (MAX_SHIFT > 1) ? $clog2(MAX_SHIFT) : 1;

  rgb_t     cell_q [MAX_SHIFT];
  logic [IW-1:0] tap_idx;

  for (genvar i = 0; i < MAX_SHIFT; i++) begin : g_cell
    if (i == 0) begin : g_head
      lcsr_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .d_in  (push_rgb),
        .q     (cell_q[i])
      );
    end else begin : g_body
      lcsr_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .d_in  (cell_q[i-1]),
        .q     (cell_q[i])
      );
    end
  end

  assign tap_idx = IW'(tap_sel - SHW'(1));

  always_comb begin
    if (tap_sel == '0) begin
      tap_rgb = push_rgb;
    end else begin
      tap_rgb = cell_q[tap_idx];
    end
  end
endmodule

FILE: hdl/laser_color_shift_realigner.sv
`timescale 1ns / 1ps
// Realigns the color of a laser sample stream against its galvo position: every beat out carries
// the position of the matching input beat and the color from color_shift beats earlier, black
// at the start of a frame, with the shift saturated at MAX_SHIFT. The color history lives in a
// row of MAX_SHIFT cells that advance together, so an ordinary sample is registered to the output
// in the cycle after it is accepted. A sample marked as frame end with a nonzero shift starts
// a flush: the cell row steps once per cycle while the output is not stalled, emitting the shift
// flush beats at the held position; the last is marked and the row cleared for the next frame.
// No input is taken in a flush. Write color_shift only while idle; the block does not enforce it.
module laser_color_shift_realigner #(
  parameter int MAX_SHIFT = 31
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lcsr_pkg::SHIFT_W-1:0] cfg_data,
  lcsr_in_if.sink                      in_s,
  lcsr_out_if.source                   out_m
);
  import lcsr_pkg::*;

  localparam int SHW = $clog2(MAX_SHIFT + 1);
  localparam int CW  = (SHW > SHIFT_W) ? SHW : SHIFT_W;

  logic [SHIFT_W-1:0]     color_shift_r;
  logic [SHW-1:0]         shift_eff;
  state_t                 state_r;
  state_t                 state_nxt;
  logic [SHW-1:0]         flush_cnt_r;
  logic [SHW-1:0]         flush_cnt_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic signed [POS_W-1:0] out_x_r;
  logic signed [POS_W-1:0] out_y_r;
  rgb_t                   out_rgb_r;
  logic                   out_last_r;

  chain_ctrl_t            ctrl;
  rgb_t                   push_rgb;
  rgb_t                   tap_rgb;
  logic                   slot_free;
  logic                   in_rdy;
  logic                   in_fire;
  logic                   emit;
  logic                   last;

  always_comb begin
    if (CW'(color_shift_r) > CW'(MAX_SHIFT)) begin
      shift_eff = SHW'(MAX_SHIFT);
    end else begin
      shift_eff = SHW'(color_shift_r);
    end
  end

  assign slot_free = !out_valid_r || out_m.ready;
  assign in_fire   = in_s.valid && in_rdy;
  assign in_s.ready = in_rdy;

  always_comb begin
    in_rdy       = 1'b0;
    emit         = 1'b0;
    last         = 1'b0;
    ctrl.advance = 1'b0;
    ctrl.clear   = 1'b0;
    push_rgb     = '{red: in_s.red, green: in_s.green, blue: in_s.blue};
    case (state_r)
      ST_RUN: begin
        in_rdy = slot_free;
        if (in_s.valid && slot_free) begin
          emit         = 1'b1;
          ctrl.advance = 1'b1;
          last         = in_s.frame_end && (shift_eff == '0);
          ctrl.clear   = last;
        end
      end
      ST_FLUSH: begin
        push_rgb = '0;
        if (slot_free) begin
          emit         = 1'b1;
          ctrl.advance = 1'b1;
          last         = (flush_cnt_r == SHW'(1));
          ctrl.clear   = last;
        end
      end
      default: begin
        in_rdy = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    flush_cnt_nxt = flush_cnt_r;
    case (state_r)
      ST_RUN: begin
        if (in_fire && in_s.frame_end && (shift_eff != '0)) begin
          state_nxt     = ST_FLUSH;
          flush_cnt_nxt = shift_eff;
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          flush_cnt_nxt = flush_cnt_r - SHW'(1);
          if (flush_cnt_r == SHW'(1)) begin
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_m.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  lcsr_delay_chain #(
    .MAX_SHIFT (MAX_SHIFT),
    .SHW       (SHW)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .push_rgb (push_rgb),
    .tap_sel  (shift_eff),
    .tap_rgb  (tap_rgb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_shift_r <= '0;
      state_r       <= ST_RUN;
      flush_cnt_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        color_shift_r <= cfg_data;
      end
      state_r     <= state_nxt;
      flush_cnt_r <= flush_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_x_r <= in_s.pos_x;
      out_y_r <= in_s.pos_y;
    end
    if (emit) begin
      out_rgb_r  <= tap_rgb;
      out_last_r <= last;
    end
  end

  assign out_m.valid         = out_valid_r;
  assign out_m.out_x         = out_x_r;
  assign out_m.out_y         = out_y_r;
  assign out_m.out_red       = out_rgb_r.red;
  assign out_m.out_green     = out_rgb_r.green;
  assign out_m.out_blue      = out_rgb_r.blue;
  assign out_m.out_frame_end = out_last_r;

  a_flush_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> (flush_cnt_r != '0))
    else $error("Flush running with an empty count.");

  a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_s.frame_end && (shift_eff != '0)) |=>
      (state_r == ST_FLUSH) && (flush_cnt_r == $past(shift_eff)) && out_valid_r)
    else $error("Frame end did not start a flush of the configured length.");

  a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && slot_free && flush_cnt_r == SHW'(1)) |=>
      (state_r == ST_RUN) && out_valid_r && out_last_r)
    else $error("Last flush beat not marked or flush did not finish.");

  a_no_input_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> !in_fire)
    else $error("Input beat taken during a flush.");
endmodule
